@@ design/sll_pkg.sv @@
// Shared types, codes and helper functions of the shell line lexer.
package sll_pkg;

	// Result kinds.
	localparam logic [2:0] KIND_BYTE = 3'd0;
	localparam logic [2:0] KIND_WEND = 3'd1;
	localparam logic [2:0] KIND_OP   = 3'd2;
	localparam logic [2:0] KIND_ERR  = 3'd3;
	localparam logic [2:0] KIND_DONE = 3'd4;

	// Operator codes; a doubled operator is its single code plus one.
	localparam logic [7:0] OPC_PIPE = 8'd0;
	localparam logic [7:0] OPC_GT   = 8'd2;
	localparam logic [7:0] OPC_LT   = 8'd4;
	localparam logic [7:0] OPC_SEMI = 8'd6;
	localparam logic [7:0] OPC_AMP  = 8'd7;

	// Special bytes.
	localparam logic [7:0] CH_PIPE  = 8'h7C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// Input item codes.
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOL  = 1'b1;

	// Quote modes.
	localparam logic [1:0] QM_OUT = 2'd0;
	localparam logic [1:0] QM_SGL = 2'd1;
	localparam logic [1:0] QM_DBL = 2'd2;

	// Held operator codes.
	localparam logic [2:0] HELD_NONE = 3'd0;
	localparam logic [2:0] HELD_PIPE = 3'd1;
	localparam logic [2:0] HELD_GT   = 3'd2;
	localparam logic [2:0] HELD_LT   = 3'd3;
	localparam logic [2:0] HELD_AMP  = 3'd4;

	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] value;
	} res_t;

	// All results caused by one input item.
	typedef struct packed {
		logic [1:0]             cnt;
		res_t [MAX_RES-1:0]     res;
	} entry_t;

	function automatic logic [2:0] held_of(input logic [7:0] c);
		logic [2:0] h;
		case (c)
			CH_PIPE: h = HELD_PIPE;
			CH_GT:   h = HELD_GT;
			CH_LT:   h = HELD_LT;
			CH_AMP:  h = HELD_AMP;
			default: h = HELD_NONE;
		endcase
		return h;
	endfunction

	function automatic logic [7:0] held_code(input logic [2:0] h);
		logic [7:0] c;
		case (h)
			HELD_PIPE: c = OPC_PIPE;
			HELD_GT:   c = OPC_GT;
			HELD_LT:   c = OPC_LT;
			default:   c = OPC_AMP;
		endcase
		return c;
	endfunction

	// Appends one result to an entry; results beyond the third are dropped.
	function automatic entry_t add_res(input entry_t e, input logic [2:0] kind,
			input logic [7:0] value);
		entry_t r;
		r = e;
		if (e.cnt != 2'd3) begin
			r.res[e.cnt].kind  = kind;
			r.res[e.cnt].value = value;
			r.cnt              = e.cnt + 2'd1;
		end
		return r;
	endfunction

endpackage

@@ design/sll_front.sv @@
// Front end: holds the lexer state and turns each accepted item into a result entry.
module sll_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            acc,
	input  logic            op,
	input  logic [7:0]      ch,
	output logic            enq,
	output sll_pkg::entry_t entry
);

	logic       word_open_q;
	logic [1:0] quote_q;
	logic [2:0] held_q;
	logic       esc_q;
	logic       qesc_q;

	logic       word_open_d;
	logic [1:0] quote_d;
	logic [2:0] held_d;
	logic       esc_d;
	logic       qesc_d;
	sll_pkg::entry_t e;

	always_comb begin
		logic cont;
		e           = '0;
		word_open_d = word_open_q;
		quote_d     = quote_q;
		held_d      = held_q;
		esc_d       = esc_q;
		qesc_d      = qesc_q;
		cont        = 1'b1;
		if (op == sll_pkg::OP_EOL) begin
			if (quote_q != sll_pkg::QM_OUT) begin
				e = sll_pkg::add_res(e, sll_pkg::KIND_ERR, 8'd0);
			end else begin
				if (held_q != sll_pkg::HELD_NONE)
					e = sll_pkg::add_res(e, sll_pkg::KIND_OP, sll_pkg::held_code(held_q));
				if (esc_q)
					e = sll_pkg::add_res(e, sll_pkg::KIND_BYTE, sll_pkg::CH_BSL);
				if (word_open_q || esc_q)
					e = sll_pkg::add_res(e, sll_pkg::KIND_WEND, 8'd0);
			end
			e           = sll_pkg::add_res(e, sll_pkg::KIND_DONE, 8'd0);
			word_open_d = 1'b0;
			quote_d     = sll_pkg::QM_OUT;
			held_d      = sll_pkg::HELD_NONE;
			esc_d       = 1'b0;
			qesc_d      = 1'b0;
		end else if (quote_q == sll_pkg::QM_SGL) begin
			if (ch == sll_pkg::CH_SQ)
				quote_d = sll_pkg::QM_OUT;
			else
				e = sll_pkg::add_res(e, sll_pkg::KIND_BYTE, ch);
		end else if (quote_q == sll_pkg::QM_DBL) begin
			if (qesc_q) begin
				qesc_d = 1'b0;
				// Only a double quote or a backslash is really escaped here.
				if (ch != sll_pkg::CH_DQ && ch != sll_pkg::CH_BSL)
					e = sll_pkg::add_res(e, sll_pkg::KIND_BYTE, sll_pkg::CH_BSL);
				e = sll_pkg::add_res(e, sll_pkg::KIND_BYTE, ch);
			end else if (ch == sll_pkg::CH_BSL) begin
				qesc_d = 1'b1;
			end else if (ch == sll_pkg::CH_DQ) begin
				quote_d = sll_pkg::QM_OUT;
			end else begin
				e = sll_pkg::add_res(e, sll_pkg::KIND_BYTE, ch);
			end
		end else if (esc_q) begin
			esc_d       = 1'b0;
			word_open_d = 1'b1;
			e           = sll_pkg::add_res(e, sll_pkg::KIND_BYTE, ch);
		end else begin
			if (held_q != sll_pkg::HELD_NONE) begin
				held_d = sll_pkg::HELD_NONE;
				if (sll_pkg::held_of(ch) == held_q) begin
					e    = sll_pkg::add_res(e, sll_pkg::KIND_OP,
						sll_pkg::held_code(held_q) + 8'd1);
					cont = 1'b0;
				end else begin
					e = sll_pkg::add_res(e, sll_pkg::KIND_OP, sll_pkg::held_code(held_q));
				end
			end
			if (cont) begin
				if (ch == sll_pkg::CH_SPACE || ch == sll_pkg::CH_TAB) begin
					if (word_open_q)
						e = sll_pkg::add_res(e, sll_pkg::KIND_WEND, 8'd0);
					word_open_d = 1'b0;
				end else if (ch == sll_pkg::CH_SQ) begin
					quote_d     = sll_pkg::QM_SGL;
					word_open_d = 1'b1;
				end else if (ch == sll_pkg::CH_DQ) begin
					quote_d     = sll_pkg::QM_DBL;
					word_open_d = 1'b1;
				end else if (ch == sll_pkg::CH_SEMI) begin
					if (word_open_q)
						e = sll_pkg::add_res(e, sll_pkg::KIND_WEND, 8'd0);
					word_open_d = 1'b0;
					e           = sll_pkg::add_res(e, sll_pkg::KIND_OP, sll_pkg::OPC_SEMI);
				end else if (sll_pkg::held_of(ch) != sll_pkg::HELD_NONE) begin
					if (word_open_q)
						e = sll_pkg::add_res(e, sll_pkg::KIND_WEND, 8'd0);
					word_open_d = 1'b0;
					held_d      = sll_pkg::held_of(ch);
				end else if (ch == sll_pkg::CH_BSL) begin
					esc_d = 1'b1;
				end else begin
					e           = sll_pkg::add_res(e, sll_pkg::KIND_BYTE, ch);
					word_open_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_open_q <= 1'b0;
			quote_q     <= sll_pkg::QM_OUT;
			held_q      <= sll_pkg::HELD_NONE;
			esc_q       <= 1'b0;
			qesc_q      <= 1'b0;
		end else if (acc) begin
			word_open_q <= word_open_d;
			quote_q     <= quote_d;
			held_q      <= held_d;
			esc_q       <= esc_d;
			qesc_q      <= qesc_d;
		end
	end

	// Items that cause no result leave nothing in the queue.
	assign enq   = acc && (e.cnt != 2'd0);
	assign entry = e;

	a_esc_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		!(esc_q && held_q != sll_pkg::HELD_NONE))
		else $error("escape pending while an operator is held");

	a_quote_valid: assert property (@(posedge clk) disable iff (!arst_n)
		quote_q != 2'd3)
		else $error("illegal quote mode");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == sll_pkg::OP_EOL |=> (quote_q == sll_pkg::QM_OUT && !word_open_q
			&& held_q == sll_pkg::HELD_NONE && !esc_q && !qesc_q))
		else $error("state not cleared after end of line");

	a_eol_enqueues: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op == sll_pkg::OP_EOL |-> enq)
		else $error("end of line produced no entry");

endmodule

@@ design/sll_fifo.sv @@
// Short queue of result entries between the front end and the back end.
module sll_fifo #(
	parameter int QDEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  sll_pkg::entry_t wdata,
	input  logic            rd,
	output sll_pkg::entry_t rdata,
	output logic            full,
	output logic            empty
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	sll_pkg::entry_t mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full  = (count_q == CW'(QDEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ design/sll_back.sv @@
// Back end: streams the results of the oldest queued entry one at a time.
module sll_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sll_pkg::entry_t head,
	input  logic            q_empty,
	input  logic            pop,
	output logic            deq,
	output logic [2:0]      kind,
	output logic [7:0]      value,
	output logic            last
);

	logic [1:0] idx_q;
	logic       taken;

	assign kind  = head.res[idx_q].kind;
	assign value = head.res[idx_q].value;
	assign last  = (idx_q == head.cnt - 2'd1);
	assign taken = pop && !q_empty;
	// The entry leaves the queue with the transfer of its final result.
	assign deq   = taken && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (taken) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> (head.cnt != 2'd0 && idx_q < head.cnt))
		else $error("result index outside the head entry");

	a_idx_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> idx_q == 2'd0)
		else $error("result index left over with an empty queue");

endmodule

@@ design/shell_line_lexer.sv @@
// An accepted item's results enter the queue as one entry and reach the result ports
// when it heads the queue. Throughput: one item per cycle while full is low; the front
// end decides all results of an item at once. An item with several results takes one
// pop per result, which the QDEPTH-entry queue absorbs; full rises only when it is full.
// Reset (arst_n low) clears the lexer state and empties the queue at once.
module shell_line_lexer #(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       op,
	input  logic [7:0] ch,
	output logic       empty,
	input  logic       pop,
	output logic [2:0] kind,
	output logic [7:0] value,
	output logic       last
);

	logic            acc;
	logic            enq;
	logic            deq;
	sll_pkg::entry_t entry;
	sll_pkg::entry_t head;

	assign acc = push && !full;

	sll_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.op     (op),
		.ch     (ch),
		.enq    (enq),
		.entry  (entry)
	);

	sll_fifo #(
		.QDEPTH (QDEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (enq),
		.wdata  (entry),
		.rd     (deq),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	sll_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (empty),
		.pop     (pop),
		.deq     (deq),
		.kind    (kind),
		.value   (value),
		.last    (last)
	);

endmodule
